/* src/pnc_pkg.sv */
// Shared types and constants for the periodic notification coalescer.
// Used by the controller, the datapath and the top level.
`default_nettype none

package pnc_pkg;

   localparam int MAX_CLIENTS = 128;
   localparam int IDX_W       = $clog2(MAX_CLIENTS);
   localparam int CNT_W       = $clog2(MAX_CLIENTS + 1);

   localparam logic [23:0] TIME_LIMIT    = 24'd500000;
   localparam logic [23:0] TIME_SAT      = 24'hFFFFFF;
   localparam logic [15:0] DEFAULT_SLICE = 16'd50;
   localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
   localparam int          PCT_SCALE     = 100;
   localparam int          PROD_W        = 31;

   // Register indexes and reset values
   localparam logic [1:0]  CSR_SLICE   = 2'd0;
   localparam logic [1:0]  CSR_PERCENT = 2'd1;
   localparam logic [1:0]  CSR_CLIENTS = 2'd2;
   localparam logic [1:0]  CSR_STOP    = 2'd3;
   localparam logic [15:0] RST_SLICE   = 16'd50;
   localparam logic [6:0]  RST_PERCENT = 7'd0;
   localparam logic [7:0]  RST_CLIENTS = 8'd1;
   localparam logic [23:0] RST_STOP    = 24'd500000;

   // Item kinds
   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_START = 2'd1;
   localparam logic [1:0] REQ_TICK  = 2'd2;
   localparam logic [1:0] REQ_SPARE = 2'd3;

   // End reasons
   localparam logic [1:0] REASON_RUN   = 2'd0;
   localparam logic [1:0] REASON_LIMIT = 2'd1;
   localparam logic [1:0] REASON_ALIGN = 2'd2;

   typedef enum logic [1:0] {
      OP_MIN = 2'd0,
      OP_UPD = 2'd1,
      OP_ALN = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      FIN_NONE  = 2'd0,
      FIN_EMIT  = 2'd1,
      FIN_START = 2'd2,
      FIN_TICK  = 2'd3
   } fin_type;

   typedef struct packed {
      logic    load;
      logic    clear_run;
      logic    sweep_init;
      logic    issue;
      op_type  op;
      fin_type fin;
   } cmd_type;

   typedef struct packed {
      logic last_issue;
      logic pipe_busy;
      logic run_done;
   } status_type;

endpackage

`default_nettype wire

/* src/pnc_ctrl.sv */
// Sequencer for the coalescer: runs the table sweeps of each item.
// Depends on pnc_pkg; drives pnc_datapath through cmd_type/status_type.
`default_nettype none

module pnc_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [1:0]         req_type,
   output logic                    busy,
   output pnc_pkg::cmd_type        cmd,
   input  wire pnc_pkg::status_type status
);
   import pnc_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_MIN      = 8'b0000_0010,
      S_MIN_WAIT = 8'b0000_0100,
      S_UPD      = 8'b0000_1000,
      S_UPD_WAIT = 8'b0001_0000,
      S_ALN      = 8'b0010_0000,
      S_ALN_WAIT = 8'b0100_0000,
      S_DONE     = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   fin_type   kind_ff, kind_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      cmd      = '{load: 1'b0, clear_run: 1'b0, sweep_init: 1'b0, issue: 1'b0,
                   op: OP_MIN, fin: FIN_NONE};
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_type)
                  REQ_LOAD: begin
                     cmd.load = 1'b1;
                     cmd.fin  = FIN_EMIT;
                  end
                  REQ_START: begin
                     cmd.clear_run  = 1'b1;
                     cmd.sweep_init = 1'b1;
                     kind_in        = FIN_START;
                     state_in       = S_ALN;
                  end
                  REQ_TICK: begin
                     if (status.run_done) begin
                        cmd.fin = FIN_EMIT;
                     end else begin
                        cmd.sweep_init = 1'b1;
                        kind_in        = FIN_TICK;
                        state_in       = S_MIN;
                     end
                  end
                  default: cmd.fin = FIN_EMIT;
               endcase
            end
         end
         S_MIN: begin
            cmd.op    = OP_MIN;
            cmd.issue = 1'b1;
            if (status.last_issue) begin
               cmd.sweep_init = 1'b1;
               state_in       = S_MIN_WAIT;
            end
         end
         S_MIN_WAIT: begin
            cmd.op = OP_MIN;
            if (!status.pipe_busy) state_in = S_UPD;
         end
         S_UPD: begin
            cmd.op    = OP_UPD;
            cmd.issue = 1'b1;
            if (status.last_issue) begin
               cmd.sweep_init = 1'b1;
               state_in       = S_UPD_WAIT;
            end
         end
         S_UPD_WAIT: begin
            cmd.op = OP_UPD;
            if (!status.pipe_busy) state_in = S_ALN;
         end
         S_ALN: begin
            cmd.op    = OP_ALN;
            cmd.issue = 1'b1;
            if (status.last_issue) begin
               cmd.sweep_init = 1'b1;
               state_in       = S_ALN_WAIT;
            end
         end
         S_ALN_WAIT: begin
            cmd.op = OP_ALN;
            if (!status.pipe_busy) state_in = S_DONE;
         end
         S_DONE: begin
            cmd.fin  = kind_ff;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= FIN_NONE;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

`default_nettype wire

/* src/pnc_datapath.sv */
// Datapath of the coalescer: client tables, sweep pipeline, run state,
// configuration registers and result registers. Depends on pnc_pkg.
`default_nettype none

module pnc_datapath (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire pnc_pkg::cmd_type   cmd,
   output pnc_pkg::status_type     status,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_index,
   input  wire logic [23:0]        csr_wdata,
   input  wire logic [6:0]         req_client_index,
   input  wire logic [15:0]        req_period,
   input  wire logic [23:0]        req_first_due,
   output logic                    rsp_valid,
   output logic [23:0]             rsp_message_time,
   output logic                    rsp_is_new_message,
   output logic [15:0]             rsp_message_count,
   output logic                    rsp_finished,
   output logic [1:0]              rsp_end_reason,
   output logic [23:0]             rsp_epoch_delay
);
   import pnc_pkg::*;

   // Client tables
   logic [15:0] per_mem [MAX_CLIENTS];
   logic [23:0] due_mem [MAX_CLIENTS];

   // Configuration
   logic [15:0] slice_ff;
   logic [6:0]  pct_ff;
   logic [7:0]  clients_ff;
   logic [23:0] stop_ff;

   // Run state
   logic [23:0] now_ff, now_in;
   logic [23:0] last_ff, last_in;
   logic        last_v_ff, last_v_in;
   logic [15:0] count_ff, count_in;
   logic [23:0] epoch_ff, epoch_in;
   logic        epoch_v_ff, epoch_v_in;
   logic        done_ff, done_in;
   logic [1:0]  reason_ff, reason_in;
   logic [23:0] delay_ff, delay_in;

   // Sweep results
   logic [23:0] base_ff;
   logic [23:0] ref_ff;
   logic        mismatch_ff;

   // Sweep pipeline
   logic [IDX_W-1:0] idx_ff;
   logic             v1_ff;
   op_type           op1_ff;
   logic [IDX_W-1:0] idx1_ff;
   logic [23:0]      d1_ff;
   logic [15:0]      p1_ff;

   logic             v2_ff;
   logic [IDX_W-1:0] idx2_ff;
   logic             hit2_ff;
   logic [23:0]      sum2_ff;
   logic             gt2_ff;
   logic             le2_ff;
   logic             pnz2_ff;
   logic [23:0]      gap2_ff;
   logic [23:0]      lim2_ff;

   logic [CNT_W-1:0] active;
   logic [15:0]      slice;
   logic             eq_mode;
   logic [24:0]      upd_sum;
   logic [23:0]      gap1;
   logic [PROD_W-1:0] gap100;
   logic             shift_ok;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [15:0]      wr_per;
   logic [23:0]      wr_due;
   logic             wr_per_en;
   logic [24:0]      now_sum;
   logic             is_new;
   logic             limit_hit;

   always_comb begin
      if (clients_ff == 8'd0) begin
         active = CNT_W'(1);
      end else if (32'(clients_ff) > MAX_CLIENTS) begin
         active = CNT_W'(MAX_CLIENTS);
      end else begin
         active = CNT_W'(clients_ff);
      end
   end

   assign slice   = (slice_ff == 16'd0) ? DEFAULT_SLICE : slice_ff;
   assign eq_mode = (base_ff == now_ff);

   assign status = '{last_issue: ({1'b0, idx_ff} == CNT_W'(active - CNT_W'(1))),
                     pipe_busy:  (v1_ff | v2_ff),
                     run_done:   done_ff};

   // Stage 1 -> 2 arithmetic
   assign upd_sum = {1'b0, d1_ff} + {9'd0, p1_ff};
   assign gap1    = d1_ff - base_ff;

   // Stage 3: percent rule as gap*100 < (percent+1)*period
   assign gap100   = PROD_W'(gap2_ff) * PROD_W'(PCT_SCALE);
   assign shift_ok = gt2_ff && (le2_ff || (pnz2_ff && (gap100 < PROD_W'(lim2_ff))));

   always_comb begin
      wr_en     = 1'b0;
      wr_per_en = 1'b0;
      wr_addr   = idx2_ff;
      wr_per    = req_period;
      wr_due    = sum2_ff;
      if (cmd.load) begin
         wr_en     = (32'(req_client_index) < MAX_CLIENTS);
         wr_per_en = wr_en;
         wr_addr   = IDX_W'(req_client_index);
         wr_due    = req_first_due;
      end else if (v2_ff) begin
         if (eq_mode) begin
            wr_en  = hit2_ff;
            wr_due = sum2_ff;
         end else begin
            wr_en  = shift_ok;
            wr_due = base_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) due_mem[wr_addr] <= wr_due;
      if (wr_per_en) per_mem[wr_addr] <= wr_per;
      d1_ff <= due_mem[idx_ff];
      p1_ff <= per_mem[idx_ff];
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      idx1_ff <= idx_ff;
      op1_ff  <= cmd.op;
      idx2_ff <= idx1_ff;
      hit2_ff <= (d1_ff == now_ff);
      sum2_ff <= upd_sum[24] ? TIME_SAT : upd_sum[23:0];
      gt2_ff  <= (d1_ff > base_ff);
      le2_ff  <= (gap1 <= {8'd0, slice});
      pnz2_ff <= (p1_ff != 16'd0);
      gap2_ff <= gap1;
      lim2_ff <= 24'({1'b0, pct_ff} + 8'd1) * 24'(p1_ff);
   end

   // Pipeline control and sweep folds
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         base_ff     <= '0;
         ref_ff      <= '0;
         mismatch_ff <= 1'b0;
      end else begin
         if (cmd.sweep_init) begin
            idx_ff <= '0;
         end else if (cmd.issue) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff && (op1_ff == OP_UPD);
         if (v1_ff && op1_ff == OP_MIN) begin
            if (idx1_ff == '0 || d1_ff < base_ff) base_ff <= d1_ff;
         end
         if (v1_ff && op1_ff == OP_ALN) begin
            if (idx1_ff == '0) begin
               ref_ff      <= d1_ff;
               mismatch_ff <= 1'b0;
            end else if (d1_ff != ref_ff) begin
               mismatch_ff <= 1'b1;
            end
         end
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slice_ff   <= RST_SLICE;
         pct_ff     <= RST_PERCENT;
         clients_ff <= RST_CLIENTS;
         stop_ff    <= RST_STOP;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SLICE:   slice_ff   <= csr_wdata[15:0];
            CSR_PERCENT: pct_ff     <= csr_wdata[6:0];
            CSR_CLIENTS: clients_ff <= csr_wdata[7:0];
            CSR_STOP:    stop_ff    <= csr_wdata;
            default:     slice_ff   <= slice_ff;
         endcase
      end
   end

   // Run state update at the end of an item
   assign now_sum   = {1'b0, now_ff} + {9'd0, slice};
   assign is_new    = !last_v_ff || (base_ff != last_ff);
   assign limit_hit = (now_ff > TIME_LIMIT) && (now_ff >= stop_ff);

   always_comb begin
      now_in     = now_ff;
      last_in    = last_ff;
      last_v_in  = last_v_ff;
      count_in   = count_ff;
      epoch_in   = epoch_ff;
      epoch_v_in = epoch_v_ff;
      done_in    = done_ff;
      reason_in  = reason_ff;
      delay_in   = delay_ff;
      if (cmd.clear_run) begin
         now_in     = '0;
         last_in    = '0;
         last_v_in  = 1'b0;
         count_in   = '0;
         epoch_in   = '0;
         epoch_v_in = 1'b0;
         done_in    = 1'b0;
         reason_in  = REASON_RUN;
         delay_in   = '0;
      end else if (cmd.fin == FIN_START) begin
         if (!mismatch_ff) begin
            epoch_in   = ref_ff;
            epoch_v_in = 1'b1;
         end
      end else if (cmd.fin == FIN_TICK) begin
         if (is_new) begin
            if (count_ff != COUNT_MAX) count_in = count_ff + 16'd1;
            last_in   = base_ff;
            last_v_in = 1'b1;
         end
         if (limit_hit) begin
            done_in   = 1'b1;
            reason_in = REASON_LIMIT;
         end else if (!mismatch_ff) begin
            if (!epoch_v_ff) begin
               epoch_in   = ref_ff;
               epoch_v_in = 1'b1;
            end else begin
               done_in   = 1'b1;
               reason_in = REASON_ALIGN;
               delay_in  = ref_ff - epoch_ff;
            end
         end
         if (!done_in) now_in = now_sum[24] ? TIME_SAT : now_sum[23:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff     <= '0;
         last_ff    <= '0;
         last_v_ff  <= 1'b0;
         count_ff   <= '0;
         epoch_ff   <= '0;
         epoch_v_ff <= 1'b0;
         done_ff    <= 1'b0;
         reason_ff  <= REASON_RUN;
         delay_ff   <= '0;
         rsp_valid  <= 1'b0;
      end else begin
         now_ff     <= now_in;
         last_ff    <= last_in;
         last_v_ff  <= last_v_in;
         count_ff   <= count_in;
         epoch_ff   <= epoch_in;
         epoch_v_ff <= epoch_v_in;
         done_ff    <= done_in;
         reason_ff  <= reason_in;
         delay_ff   <= delay_in;
         rsp_valid  <= (cmd.fin != FIN_NONE);
      end
   end

   // Result registers
   always_ff @(posedge clock) begin
      if (cmd.fin == FIN_TICK) begin
         rsp_message_time   <= base_ff;
         rsp_is_new_message <= is_new;
      end else begin
         rsp_message_time   <= last_in;
         rsp_is_new_message <= 1'b0;
      end
      rsp_message_count <= count_in;
      rsp_finished      <= done_in;
      rsp_end_reason    <= reason_in;
      rsp_epoch_delay   <= delay_in;
   end

endmodule

`default_nettype wire

/* src/periodic_notification_coalescer_top.sv */
// Top level of the periodic notification coalescer.
// A load or a tick after the end of a run: result in the cycle after start.
// A start item makes one pass (align) over the client tables; a live tick makes three
// (minimum, update, align), each over the active clients of the single-read-port tables.
// One item at a time; busy falls with the result, in the cycle a new item can be taken.
// Reset (synchronous): run state cleared, registers at defaults, tables undefined.
`default_nettype none

module periodic_notification_coalescer_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_type,
   input  wire logic [6:0]  req_client_index,
   input  wire logic [15:0] req_period,
   input  wire logic [23:0] req_first_due,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [23:0] csr_wdata,
   output logic             rsp_valid,
   output logic [23:0]      rsp_message_time,
   output logic             rsp_is_new_message,
   output logic [15:0]      rsp_message_count,
   output logic             rsp_finished,
   output logic [1:0]       rsp_end_reason,
   output logic [23:0]      rsp_epoch_delay
);
   import pnc_pkg::*;

   cmd_type    cmd;
   status_type status;

   pnc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .busy     (busy),
      .cmd      (cmd),
      .status   (status)
   );

   pnc_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_client_index   (req_client_index),
      .req_period         (req_period),
      .req_first_due      (req_first_due),
      .rsp_valid          (rsp_valid),
      .rsp_message_time   (rsp_message_time),
      .rsp_is_new_message (rsp_is_new_message),
      .rsp_message_count  (rsp_message_count),
      .rsp_finished       (rsp_finished),
      .rsp_end_reason     (rsp_end_reason),
      .rsp_epoch_delay    (rsp_epoch_delay)
   );

endmodule

`default_nettype wire

/* tb/sv/periodic_notification_coalescer_checker.sv */
// Scoreboard for the periodic notification coalescer: watches the item, result
// and register ports, predicts each result and compares it field by field.
// Depends on pnc_pkg for item kinds, register indexes and widths.
module periodic_notification_coalescer_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_type,
   input  logic [6:0]  req_client_index,
   input  logic [15:0] req_period,
   input  logic [23:0] req_first_due,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata,
   input  logic        rsp_valid,
   input  logic [23:0] rsp_message_time,
   input  logic        rsp_is_new_message,
   input  logic [15:0] rsp_message_count,
   input  logic        rsp_finished,
   input  logic [1:0]  rsp_end_reason,
   input  logic [23:0] rsp_epoch_delay,
   output int          mismatches,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import pnc_pkg::*;

   typedef struct packed {
      logic [23:0] message_time;
      logic        is_new;
      logic [15:0] count;
      logic        finished;
      logic [1:0]  reason;
      logic [23:0] delay;
   } report_type;

   report_type  expected_reports[$];

   logic [15:0] period_mem[MAX_CLIENTS];
   logic [23:0] due_mem[MAX_CLIENTS];
   logic [23:0] now_ms, last_msg, epoch_at, delay_ms;
   logic        last_seen, epoch_seen, done;
   logic [15:0] distinct;
   logic [1:0]  reason;
   logic [15:0] slice_cfg;
   logic [6:0]  percent_cfg;
   logic [7:0]  clients_cfg;
   logic [23:0] stop_cfg;

   function automatic int live_clients();
      if (clients_cfg == 0) return 1;
      if (clients_cfg > MAX_CLIENTS) return MAX_CLIENTS;
      return clients_cfg;
   endfunction

   function automatic logic [23:0] add_clamped(logic [23:0] a, logic [23:0] b);
      logic [24:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[24] ? TIME_SAT : s[23:0];
   endfunction

   // Record the first full alignment; report a repeat.
   function automatic bit aligned_again();
      int n;
      n = live_clients();
      for (int i = 1; i < n; i++)
         if (due_mem[i] != due_mem[0]) return 0;
      if (!epoch_seen) begin
         epoch_at = due_mem[0];
         epoch_seen = 1;
         return 0;
      end
      delay_ms = due_mem[0] - epoch_at;
      return 1;
   endfunction

   function automatic report_type coalesce_item(logic [1:0] kind, logic [6:0] idx,
                                                logic [15:0] per, logic [23:0] due);
      report_type r;
      int n;
      logic [23:0] base, nowv, slice;
      longint gap;
      bit fresh;
      r.message_time = last_msg;
      r.is_new = 0;
      if (kind == REQ_LOAD) begin
         period_mem[idx] = per;
         due_mem[idx] = due;
         r.message_time = last_msg;
      end else if (kind == REQ_START) begin
         now_ms = 0; last_msg = 0; last_seen = 0; distinct = 0;
         epoch_at = 0; epoch_seen = 0; done = 0; reason = REASON_RUN; delay_ms = 0;
         void'(aligned_again());
         r.message_time = last_msg;
      end else if (kind == REQ_TICK && !done) begin
         n = live_clients();
         nowv = now_ms;
         slice = (slice_cfg == 0) ? DEFAULT_SLICE : slice_cfg;
         base = due_mem[0];
         for (int i = 1; i < n; i++)
            if (due_mem[i] < base) base = due_mem[i];
         if (base == nowv) begin
            for (int i = 0; i < n; i++)
               if (due_mem[i] == nowv) due_mem[i] = add_clamped(due_mem[i], period_mem[i]);
         end else begin
            for (int i = 0; i < n; i++) begin
               if (due_mem[i] > base) begin
                  gap = due_mem[i] - base;
                  if (gap <= slice)
                     due_mem[i] = base;
                  else if (period_mem[i] != 0 && (gap * 100) / period_mem[i] <= percent_cfg)
                     due_mem[i] = base;
               end
            end
         end
         fresh = !last_seen || base != last_msg;
         if (fresh) begin
            if (distinct != COUNT_MAX) distinct++;
            last_msg = base;
            last_seen = 1;
         end
         // time limit wins over a repeated alignment
         if (nowv > TIME_LIMIT && nowv >= stop_cfg) begin
            done = 1; reason = REASON_LIMIT;
         end else if (aligned_again()) begin
            done = 1; reason = REASON_ALIGN;
         end
         if (!done) now_ms = add_clamped(now_ms, slice);
         r.message_time = base;
         r.is_new = fresh;
      end
      r.count = distinct;
      r.finished = done;
      r.reason = reason;
      r.delay = delay_ms;
      return r;
   endfunction

   always @(posedge clock) begin
      report_type want;
      if (reset) begin
         expected_reports.delete();
         now_ms = 0; last_msg = 0; epoch_at = 0; delay_ms = 0;
         last_seen = 0; epoch_seen = 0; done = 0; distinct = 0;
         reason = REASON_RUN;
         slice_cfg = RST_SLICE; percent_cfg = RST_PERCENT;
         clients_cfg = RST_CLIENTS; stop_cfg = RST_STOP;
         mismatches <= 0;
         pending <= 0;
      end else begin
         if (rsp_valid) begin
            if (expected_reports.size() == 0) begin
               if (mismatches < 10) $display("%0t: result with nothing expected", $realtime);
               mismatches <= mismatches + 1;
            end else begin
               want = expected_reports.pop_front();
               if (want.message_time !== rsp_message_time || want.is_new !== rsp_is_new_message
                   || want.count !== rsp_message_count || want.finished !== rsp_finished
                   || want.reason !== rsp_end_reason || want.delay !== rsp_epoch_delay) begin
                  if (mismatches < 10)
                     $display("%0t: want %h %b %0d %b %0d %h, got %h %b %0d %b %0d %h",
                              $realtime, want.message_time, want.is_new, want.count,
                              want.finished, want.reason, want.delay, rsp_message_time,
                              rsp_is_new_message, rsp_message_count, rsp_finished,
                              rsp_end_reason, rsp_epoch_delay);
                  mismatches <= mismatches + 1;
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_SLICE:   slice_cfg = csr_wdata[15:0];
               CSR_PERCENT: percent_cfg = csr_wdata[6:0];
               CSR_CLIENTS: clients_cfg = csr_wdata[7:0];
               CSR_STOP:    stop_cfg = csr_wdata;
            endcase
         end
         if (start && !busy)
            expected_reports.push_back(coalesce_item(req_type, req_client_index,
                                                     req_period, req_first_due));
         pending <= expected_reports.size();
      end
   end
endmodule

/* tb/sv/periodic_notification_coalescer_top_tb.sv */
// Stimulus top for the periodic notification coalescer: clock, reset, item and
// register traffic; checking is left to periodic_notification_coalescer_checker.
// Depends on pnc_pkg and periodic_notification_coalescer_top.
module periodic_notification_coalescer_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pnc_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_type = REQ_LOAD;
   logic [6:0]  req_client_index = 0;
   logic [15:0] req_period = 0;
   logic [23:0] req_first_due = 0;
   logic        csr_we = 0;
   logic [1:0]  csr_index = CSR_SLICE;
   logic [23:0] csr_wdata = 0;
   logic        rsp_valid, rsp_is_new_message, rsp_finished;
   logic [23:0] rsp_message_time, rsp_epoch_delay;
   logic [15:0] rsp_message_count;
   logic [1:0]  rsp_end_reason;
   int          mismatches, pending;
   int          items_sent = 0;

   always #2 clock = ~clock;

   periodic_notification_coalescer_top uut (.*);
   periodic_notification_coalescer_checker scoreboard (.*);

   // Hold start until the item is taken; idle now and then except near the end.
   task automatic send(logic [1:0] kind, logic [6:0] idx, logic [15:0] per, logic [23:0] due);
      start <= 1;
      req_type <= kind;
      req_client_index <= idx;
      req_period <= per;
      req_first_due <= due;
      do @(posedge clock); while (busy);
      items_sent++;
      if (items_sent < 480 && $urandom_range(0, 3) == 0) begin
         start <= 0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 0;
      do @(posedge clock); while (pending != 0 || busy);
   endtask

   task automatic configure(logic [15:0] slice, logic [6:0] pct, logic [7:0] clients,
                            logic [23:0] stop_at);
      drain();
      csr_we <= 1; csr_index <= CSR_SLICE; csr_wdata <= {8'd0, slice};
      @(posedge clock);
      csr_index <= CSR_PERCENT; csr_wdata <= {17'd0, pct};
      @(posedge clock);
      csr_index <= CSR_CLIENTS; csr_wdata <= {16'd0, clients};
      @(posedge clock);
      csr_index <= CSR_STOP; csr_wdata <= stop_at;
      @(posedge clock);
      csr_we <= 0;
   endtask

   task automatic random_run();
      int n, ticks, pick;
      logic [15:0] slice;
      logic [23:0] common;
      logic [7:0]  clients;
      pick = $urandom_range(0, 9);
      n = (pick < 7) ? $urandom_range(1, 6) : (pick < 9) ? $urandom_range(7, 20) : MAX_CLIENTS;
      clients = 8'(n);
      if (n == 1 && $urandom_range(0, 1)) clients = 0;
      if (n == MAX_CLIENTS && $urandom_range(0, 1)) clients = 8'hFF;
      case ($urandom_range(0, 4))
         0: slice = 0;
         1: slice = 1;
         2: slice = 65535;
         default: slice = 16'($urandom_range(1, 200));
      endcase
      configure(slice, 7'($urandom_range(0, 3) == 0 ? 100 : $urandom_range(0, 100)), clients,
                24'($urandom_range(0, 3) == 0 ? $urandom_range(0, 24'hFFFFFF) :
                                                $urandom_range(0, 600000)));
      common = 24'($urandom_range(0, 3) * 50);
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 19);
         send(REQ_LOAD, 7'(i),
              16'(pick == 0 ? 0 : pick == 1 ? $urandom : $urandom_range(1, 500)),
              24'(pick < 10 ? common : pick == 19 ? $urandom : $urandom_range(0, 1000)));
      end
      send(REQ_START, 7'($urandom), 16'($urandom), 24'($urandom));
      ticks = $urandom_range(10, 40);
      for (int t = 0; t < ticks; t++) begin
         pick = $urandom_range(0, 19);
         if (pick == 0)
            send(REQ_SPARE, 7'($urandom), 16'($urandom), 24'($urandom));
         else if (pick == 1)
            send(REQ_LOAD, 7'($urandom), 16'($urandom), 24'($urandom_range(0, 1000)));
         else
            send(REQ_TICK, 7'($urandom), 16'($urandom), 24'($urandom));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // write every entry so no run ever reads an unwritten one
      for (int i = 0; i < MAX_CLIENTS; i++)
         send(REQ_LOAD, 7'(i), 16'($urandom), 24'($urandom));

      // repeated alignment: two clients both due at zero
      configure(50, 0, 2, 0);
      send(REQ_LOAD, 0, 100, 0);
      send(REQ_LOAD, 1, 200, 0);
      send(REQ_START, 0, 0, 0);
      repeat (4) send(REQ_TICK, 7'h7F, 16'hFFFF, 24'hFFFFFF);
      send(REQ_SPARE, 0, 0, 0);

      // zero slice and zero client count, far-off due time
      configure(0, 100, 0, 24'hFFFFFF);
      send(REQ_LOAD, 0, 0, 24'hFFFFF0);
      send(REQ_START, 0, 0, 0);
      repeat (2) send(REQ_TICK, 0, 0, 0);

      // percent pull versus zero period client
      configure(1, 100, 3, 0);
      send(REQ_LOAD, 0, 1000, 0);
      send(REQ_LOAD, 1, 0, 500);
      send(REQ_LOAD, 2, 1000, 900);
      send(REQ_START, 0, 0, 0);
      repeat (3) send(REQ_TICK, 0, 0, 0);

      // clamped client count
      configure(65535, 100, 8'hFF, 0);
      send(REQ_START, 0, 0, 0);
      send(REQ_TICK, 0, 0, 0);

      // long run: a single client always realigns, so the first tick ends it by alignment
      configure(65535, 0, 1, 24'hFFFFFF);
      send(REQ_LOAD, 0, 16'hFFFF, 0);
      send(REQ_START, 0, 0, 0);
      repeat (262) send(REQ_TICK, 0, 0, 0);

      while (items_sent < 560) random_run();
      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #40ms;
      $display("end of test: mismatches");
      $finish;
   end
endmodule

/* periodic_notification_coalescer_top.f */
src/pnc_pkg.sv
src/pnc_ctrl.sv
src/pnc_datapath.sv
src/periodic_notification_coalescer_top.sv
tb/sv/periodic_notification_coalescer_checker.sv
tb/sv/periodic_notification_coalescer_top_tb.sv
